FILE: hdl/bcdas_pkg.sv
package bcdas_pkg;

    localparam int LANE_W = 8;
    localparam int LANES  = 4;
    localparam int WORD_W = LANE_W * LANES;

    // decimal correction constants
    localparam logic [3:0] DIGIT_MAX = 4'h9;
    localparam logic [3:0] DIGIT_ADJ = 4'h6;
    localparam logic [7:0] BYTE_MAX  = 8'h99;
    localparam logic [7:0] BYTE_ADJ  = 8'hA0;

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } op_t;

    // what travels from one lane cell to the next
    typedef struct packed {
        op_t                op;
        logic               carry;
        logic [WORD_W-1:0]  a;
        logic [WORD_W-1:0]  b;
        logic [WORD_W-1:0]  r;
    } beat_t;

    // one byte lane: returns {carry or borrow out, result byte}
    function automatic logic [LANE_W:0] lane_step(
        input op_t               op,
        input logic [LANE_W-1:0] a,
        input logic [LANE_W-1:0] b,
        input logic              cin
    );
        logic [9:0]  s;
        logic [15:0] d;
        logic        c;
        logic [7:0]  v;
        s = 10'd0;
        d = 16'd0;
        c = 1'b0;
        v = 8'd0;
        case (op)
            OP_ADD:
            begin
                s = {6'd0, a[3:0]} + {6'd0, b[3:0]} + {9'd0, cin};
                if (s > {6'd0, DIGIT_MAX})
                begin
                    s = s + {6'd0, DIGIT_ADJ};
                end
                s = s + {2'd0, a[7:4], 4'd0} + {2'd0, b[7:4], 4'd0};
                if (s > {2'd0, BYTE_MAX})
                begin
                    s = s - {2'd0, BYTE_ADJ};
                    c = 1'b1;
                end
                v = s[7:0];
            end
            OP_SUB:
            begin
                // 16-bit wrap matches the two's complement low-half compare
                d = {12'd0, b[3:0]} - {12'd0, a[3:0]} - {15'd0, cin};
                if (d[7:0] > {4'd0, DIGIT_MAX})
                begin
                    d = d - {12'd0, DIGIT_ADJ};
                end
                d = d + {8'd0, b[7:4], 4'd0} - {8'd0, a[7:4], 4'd0};
                if (d > {8'd0, BYTE_MAX})
                begin
                    d = d + {8'd0, BYTE_ADJ};
                    c = 1'b1;
                end
                v = d[7:0];
            end
            default:
            begin
                v = 8'd0;
                c = 1'b0;
            end
        endcase
        return {c, v};
    endfunction

endpackage

FILE: hdl/bcdas_cell.sv
module bcdas_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    output logic            up_stall,
    input  bcdas_pkg::beat_t up_beat,
    output logic            down_valid,
    input  logic            down_stall,
    output bcdas_pkg::beat_t down_beat
);

    logic             valid_reg;
    logic             valid_next;
    bcdas_pkg::beat_t beat_reg;
    bcdas_pkg::beat_t beat_next;
    logic             take;
    logic [bcdas_pkg::LANE_W:0] lane;

    assign up_stall = valid_reg & down_stall;
    assign take     = up_valid & ~up_stall;

    assign lane = bcdas_pkg::lane_step(up_beat.op,
                                       up_beat.a[bcdas_pkg::LANE_W-1:0],
                                       up_beat.b[bcdas_pkg::LANE_W-1:0],
                                       up_beat.carry);

    // consume the low byte, shift the result byte in from the top
    always_comb
    begin
        beat_next.op    = up_beat.op;
        beat_next.carry = lane[bcdas_pkg::LANE_W];
        beat_next.a     = up_beat.a >> bcdas_pkg::LANE_W;
        beat_next.b     = up_beat.b >> bcdas_pkg::LANE_W;
        beat_next.r     = {lane[bcdas_pkg::LANE_W-1:0],
                           up_beat.r[bcdas_pkg::WORD_W-1:bcdas_pkg::LANE_W]};
    end

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (down_stall)
        begin
            valid_next = valid_reg;
        end
        else
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= beat_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_beat  = beat_reg;

endmodule

FILE: hdl/packed_bcd_add_subtract.sv
// Packed-BCD adder/subtractor for eight-digit words. operation 0 returns
// operand_b + operand_a, operation 1 returns operand_b - operand_a; the final
// decimal carry or borrow is dropped, so results wrap modulo 10^8 for valid
// BCD inputs (non-BCD digits pass through the same byte rules unchecked).
// The work runs through a row of four byte-lane cells, low byte first, each
// a register stage that hands the decimal carry/borrow to the next. An
// accepted input beat passes the four cell registers in order to the result,
// and a new beat is taken every cycle unless the stall reaches the first cell;
// a held result only stops as many cells as are full behind it, so empty cells keep taking input.
module packed_bcd_add_subtract (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] result
);

    // handshake and beat wiring between neighboring cells
    logic             valid_w [bcdas_pkg::LANES+1];
    logic             stall_w [bcdas_pkg::LANES+1];
    bcdas_pkg::beat_t beat_w  [bcdas_pkg::LANES+1];

    // head of the row: carry in is clear, result field starts empty
    always_comb
    begin
        beat_w[0].op    = bcdas_pkg::op_t'(operation);
        beat_w[0].carry = 1'b0;
        beat_w[0].a     = operand_a;
        beat_w[0].b     = operand_b;
        beat_w[0].r     = '0;
    end

    assign valid_w[0] = in_valid;
    assign in_stall   = stall_w[0];

    genvar i;
    generate
        for (i = 0; i < bcdas_pkg::LANES; i++)
        begin : g_lane
            bcdas_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .up_valid   (valid_w[i]),
                .up_stall   (stall_w[i]),
                .up_beat    (beat_w[i]),
                .down_valid (valid_w[i+1]),
                .down_stall (stall_w[i+1]),
                .down_beat  (beat_w[i+1])
            );
        end
    endgenerate

    // tail of the row: all result bytes have been shifted into place
    assign stall_w[bcdas_pkg::LANES] = out_stall;
    assign out_valid = valid_w[bcdas_pkg::LANES];
    assign result    = beat_w[bcdas_pkg::LANES].r;

endmodule
